// ----- rtl/gww_pkg.sv -----
`timescale 1ns / 1ps

package gww_pkg;

    localparam int GWW_POS_BITS = 16;

    localparam int GWW_QUEUE_DEPTH = 4;
    localparam int GWW_PTR_BITS    = $clog2(GWW_QUEUE_DEPTH);
    localparam int GWW_CNT_BITS    = $clog2(GWW_QUEUE_DEPTH + 1);

    localparam logic [15:0] GWW_MAX_WIDTH_RESET = 16'd320;
    localparam logic [15:0] GWW_WIDTH_SAT       = 16'hFFFF;

    localparam logic [2:0] KIND_ORDINARY = 3'd0;
    localparam logic [2:0] KIND_SPACE    = 3'd1;
    localparam logic [2:0] KIND_NEWLINE  = 3'd2;
    localparam logic [2:0] KIND_CR       = 3'd3;
    localparam logic [2:0] KIND_EOT      = 3'd4;

    typedef enum logic [1:0] {
        CLS_ORDINARY,
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_EOT
    } gww_class_t;

    typedef struct packed {
        gww_class_t  cls;
        logic [7:0]  char_width;
    } gww_item_ctl_t;

endpackage

// ----- rtl/gww_front.sv -----
`timescale 1ns / 1ps

module gww_front #(
    parameter int POS_BITS = gww_pkg::GWW_POS_BITS
) (
    input  logic [2:0]            kind,
    input  logic [7:0]            char_width,
    input  logic [15:0]           char_pos,
    input  logic [2:0]            char_len,
    output logic                  keep,
    output gww_pkg::gww_item_ctl_t ctl,
    output logic [POS_BITS-1:0]   pos,
    output logic [POS_BITS-1:0]   after
);
    import gww_pkg::*;

    // Carriage returns and unknown codes are accepted and dropped here.
    always_comb
    begin
        keep = 1'b1;
        ctl.cls = CLS_ORDINARY;
        ctl.char_width = char_width;
        case (kind)
            KIND_ORDINARY: ctl.cls = CLS_ORDINARY;
            KIND_SPACE:    ctl.cls = CLS_SPACE;
            KIND_NEWLINE:  ctl.cls = CLS_NEWLINE;
            KIND_EOT:      ctl.cls = CLS_EOT;
            KIND_CR:       keep = 1'b0;
            default:       keep = 1'b0;
        endcase
    end

    assign pos   = POS_BITS'(char_pos);
    assign after = pos + POS_BITS'(char_len);

endmodule

// ----- rtl/gww_queue.sv -----
`timescale 1ns / 1ps

module gww_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    import gww_pkg::*;

    logic [WIDTH-1:0]        slot_reg [GWW_QUEUE_DEPTH];
    logic [GWW_PTR_BITS-1:0] wr_ptr_reg;
    logic [GWW_PTR_BITS-1:0] wr_ptr_next;
    logic [GWW_PTR_BITS-1:0] rd_ptr_reg;
    logic [GWW_PTR_BITS-1:0] rd_ptr_next;
    logic [GWW_CNT_BITS-1:0] count_reg;
    logic [GWW_CNT_BITS-1:0] count_next;

    assign full      = (count_reg == GWW_CNT_BITS'(GWW_QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? GWW_PTR_BITS'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? GWW_PTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/gww_back.sv -----
`timescale 1ns / 1ps

module gww_back #(
    parameter int POS_BITS = gww_pkg::GWW_POS_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   max_width_wr,
    input  logic [15:0]            max_width,
    input  logic                   item_valid,
    input  gww_pkg::gww_item_ctl_t item_ctl,
    input  logic [POS_BITS-1:0]    item_pos,
    input  logic [POS_BITS-1:0]    item_after,
    output logic                   item_take,
    output logic                   line_valid,
    input  logic                   line_stall,
    output logic [15:0]            line_start,
    output logic [15:0]            line_len,
    output logic [15:0]            line_width,
    output logic                   final_line
);
    import gww_pkg::*;

    logic [15:0]         max_width_reg;
    logic [POS_BITS-1:0] start_reg;
    logic [POS_BITS-1:0] start_next;
    logic [POS_BITS-1:0] bpos_reg;
    logic [POS_BITS-1:0] bpos_next;
    logic                bvalid_reg;
    logic                bvalid_next;
    logic [15:0]         wbs_reg;
    logic [15:0]         wbs_next;
    logic [7:0]          bsw_reg;
    logic [7:0]          bsw_next;
    logic [15:0]         rw_reg;
    logic [15:0]         rw_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [15:0]         out_start_reg;
    logic [15:0]         out_len_reg;
    logic [15:0]         out_width_reg;
    logic                out_final_reg;

    logic [16:0]         sum;
    logic [15:0]         sum_sat;
    logic                overflow;
    logic [16:0]         removed;
    logic [16:0]         remain;
    logic                emit;
    logic [POS_BITS-1:0] e_start;
    logic [POS_BITS-1:0] e_end;
    logic [POS_BITS-1:0] e_len;
    logic [15:0]         e_width;
    logic                e_final;

    assign item_take = item_valid && (!out_valid_reg || !line_stall);

    assign sum      = {1'b0, rw_reg} + 17'(item_ctl.char_width);
    assign sum_sat  = sum[16] ? GWW_WIDTH_SAT : sum[15:0];
    assign overflow = (sum > {1'b0, max_width_reg});
    assign removed  = {1'b0, wbs_reg} + 17'(bsw_reg);
    assign remain   = sum - removed;

    always_comb
    begin
        start_next  = start_reg;
        bpos_next   = bpos_reg;
        bvalid_next = bvalid_reg;
        wbs_next    = wbs_reg;
        bsw_next    = bsw_reg;
        rw_next     = rw_reg;
        emit        = 1'b0;
        e_start     = start_reg;
        e_end       = item_pos;
        e_width     = rw_reg;
        e_final     = 1'b0;
        if (item_take)
        begin
            case (item_ctl.cls)
                CLS_NEWLINE:
                begin
                    emit = 1'b1;
                    if (rw_reg == '0)
                    begin
                        e_end   = start_reg;
                        e_width = '0;
                    end
                    start_next = item_after;
                    rw_next    = '0;
                end
                CLS_EOT:
                begin
                    emit       = (rw_reg != '0);
                    e_final    = 1'b1;
                    start_next = '0;
                    rw_next    = '0;
                end
                CLS_SPACE:
                begin
                    if (overflow || rw_reg == '0)
                    begin
                        emit       = overflow && (rw_reg != '0);
                        start_next = item_after;
                        rw_next    = '0;
                    end
                    else
                    begin
                        bpos_next   = item_pos;
                        bvalid_next = 1'b1;
                        wbs_next    = rw_reg;
                        bsw_next    = item_ctl.char_width;
                        rw_next     = sum_sat;
                    end
                end
                default:
                begin
                    if (!overflow)
                    begin
                        rw_next = sum_sat;
                    end
                    else if (bvalid_reg)
                    begin
                        emit       = (wbs_reg != '0);
                        e_end      = bpos_reg;
                        e_width    = wbs_reg;
                        start_next = bpos_reg + POS_BITS'(1);
                        if (sum > removed)
                        begin
                            rw_next = remain[16] ? GWW_WIDTH_SAT : remain[15:0];
                        end
                        else
                        begin
                            rw_next = '0;
                        end
                    end
                    else
                    begin
                        emit       = (rw_reg != '0);
                        start_next = item_pos;
                        rw_next    = 16'(item_ctl.char_width);
                    end
                end
            endcase
            // Every line break forgets the remembered space.
            if (item_ctl.cls != CLS_SPACE || overflow || rw_reg == '0)
            begin
                if (item_ctl.cls != CLS_ORDINARY || overflow)
                begin
                    bpos_next   = '0;
                    bvalid_next = 1'b0;
                    wbs_next    = '0;
                    bsw_next    = '0;
                end
            end
        end
    end

    assign e_len = e_end - e_start;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take)
        begin
            out_valid_next = emit;
        end
        else if (!line_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg <= GWW_MAX_WIDTH_RESET;
            start_reg     <= '0;
            bpos_reg      <= '0;
            bvalid_reg    <= 1'b0;
            wbs_reg       <= '0;
            bsw_reg       <= '0;
            rw_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (max_width_wr)
            begin
                max_width_reg <= max_width;
            end
            start_reg     <= start_next;
            bpos_reg      <= bpos_next;
            bvalid_reg    <= bvalid_next;
            wbs_reg       <= wbs_next;
            bsw_reg       <= bsw_next;
            rw_reg        <= rw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && emit)
        begin
            out_start_reg <= 16'(32'(e_start));
            out_len_reg   <= 16'(32'(e_len));
            out_width_reg <= e_width;
            out_final_reg <= e_final;
        end
    end

    assign line_valid = out_valid_reg;
    assign line_start = out_start_reg;
    assign line_len   = out_len_reg;
    assign line_width = out_width_reg;
    assign final_line = out_final_reg;

endmodule

// ----- rtl/greedy_word_wrap.sv -----
`timescale 1ns / 1ps

// Channel    Direction  Handshake                 Payload
// char       in         char_valid / char_stall   kind, char_width, char_pos, char_len
// line       out        line_valid / line_stall   line_start, line_len, line_width, final_line
// max_width  in         max_width_wr              max_width
//
// One character is taken every cycle while char_stall is low; a line record passes through
// the queue and then the output register after the character that closes it.
// Reset clears all line state and the queue and sets max_width to 320.
// While line_stall holds back a waiting line record the queue of four items fills, after which char_stall rises.

module greedy_word_wrap #(
    parameter int POS_BITS = gww_pkg::GWW_POS_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        max_width_wr,
    input  logic [15:0] max_width,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  char_width,
    input  logic [15:0] char_pos,
    input  logic [2:0]  char_len,
    output logic        line_valid,
    input  logic        line_stall,
    output logic [15:0] line_start,
    output logic [15:0] line_len,
    output logic [15:0] line_width,
    output logic        final_line
);
    import gww_pkg::*;

    localparam int ITEM_BITS = $bits(gww_item_ctl_t) + 2 * POS_BITS;

    logic                keep;
    gww_item_ctl_t       f_ctl;
    logic [POS_BITS-1:0] f_pos;
    logic [POS_BITS-1:0] f_after;
    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_not_empty;
    logic [ITEM_BITS-1:0] q_out;
    gww_item_ctl_t       b_ctl;
    logic [POS_BITS-1:0] b_pos;
    logic [POS_BITS-1:0] b_after;

    gww_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .kind       (kind),
        .char_width (char_width),
        .char_pos   (char_pos),
        .char_len   (char_len),
        .keep       (keep),
        .ctl        (f_ctl),
        .pos        (f_pos),
        .after      (f_after)
    );

    assign char_stall = q_full;
    assign q_push     = char_valid && !q_full && keep;

    gww_queue #(
        .WIDTH (ITEM_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ctl, f_pos, f_after}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign {b_ctl, b_pos, b_after} = q_out;

    gww_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_width_wr (max_width_wr),
        .max_width    (max_width),
        .item_valid   (q_not_empty),
        .item_ctl     (b_ctl),
        .item_pos     (b_pos),
        .item_after   (b_after),
        .item_take    (q_pop),
        .line_valid   (line_valid),
        .line_stall   (line_stall),
        .line_start   (line_start),
        .line_len     (line_len),
        .line_width   (line_width),
        .final_line   (final_line)
    );

endmodule

// ----- verif/line_checker.sv -----
`timescale 1ns / 1ps

module line_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        max_width_wr,
    input  logic [15:0] max_width,
    input  logic        char_valid,
    input  logic        char_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  char_width,
    input  logic [15:0] char_pos,
    input  logic [2:0]  char_len,
    input  logic        line_valid,
    input  logic        line_stall,
    input  logic [15:0] line_start,
    input  logic [15:0] line_len,
    input  logic [15:0] line_width,
    input  logic        final_line,
    output int          pending,
    output int          errors
);
    import gww_pkg::*;

    localparam int PB = GWW_POS_BITS;

    typedef struct packed {
        logic [15:0] lstart;
        logic [15:0] llen;
        logic [15:0] lwidth;
        logic        lfinal;
    } line_rec_t;

    line_rec_t     lines_due[$];
    logic [15:0]   wrap_limit;
    logic [PB-1:0] line_head;
    logic [PB-1:0] brk_pos;
    logic          brk_seen;
    logic [15:0]   width_to_brk;
    logic [7:0]    brk_width;
    logic [15:0]   run_width;

    function automatic logic [15:0] sat16(input int unsigned v);
        return (v > GWW_WIDTH_SAT) ? GWW_WIDTH_SAT : 16'(v);
    endfunction

    function automatic line_rec_t make_line(input logic [PB-1:0] from, input logic [PB-1:0] upto,
                                            input logic [15:0] w, input logic fin);
        line_rec_t     r;
        logic [PB-1:0] span;
        span     = upto - from;
        r.lstart = 16'(from);
        r.llen   = 16'(span);
        r.lwidth = w;
        r.lfinal = fin;
        return r;
    endfunction

    function automatic void forget_brk();
        brk_pos      = '0;
        brk_seen     = 1'b0;
        width_to_brk = '0;
        brk_width    = '0;
    endfunction

    // Advances the line state by one character and says whether a line is closed by it.
    function automatic bit wrap_char(input logic [2:0] k, input logic [7:0] w,
                                     input logic [15:0] p, input logic [2:0] l,
                                     output line_rec_t r);
        logic [PB-1:0] at;
        logic [PB-1:0] after;
        int unsigned   reach;
        int unsigned   removed;
        bit            made;
        at    = p;
        after = at + l;
        reach = run_width + w;
        made  = 1'b0;
        r     = '0;
        if (k == KIND_NEWLINE) begin
            r         = make_line(line_head, (run_width != 0) ? at : line_head, run_width, 1'b0);
            made      = 1'b1;
            line_head = after;
            run_width = '0;
            forget_brk();
        end else if (k == KIND_EOT) begin
            if (run_width != 0) begin
                r    = make_line(line_head, at, run_width, 1'b1);
                made = 1'b1;
            end
            line_head = '0;
            run_width = '0;
            forget_brk();
        end else if (k != KIND_ORDINARY && k != KIND_SPACE) begin
            made = 1'b0;
        end else if (reach > wrap_limit) begin
            if (k == KIND_SPACE) begin
                if (run_width != 0) begin
                    r    = make_line(line_head, at, run_width, 1'b0);
                    made = 1'b1;
                end
                line_head = after;
                run_width = '0;
            end else if (brk_seen) begin
                removed = width_to_brk + brk_width;
                if (width_to_brk != 0) begin
                    r    = make_line(line_head, brk_pos, width_to_brk, 1'b0);
                    made = 1'b1;
                end
                line_head = brk_pos + 1'b1;
                run_width = (reach > removed) ? sat16(reach - removed) : 16'd0;
            end else begin
                if (run_width != 0) begin
                    r    = make_line(line_head, at, run_width, 1'b0);
                    made = 1'b1;
                end
                line_head = at;
                run_width = w;
            end
            forget_brk();
        end else if (k == KIND_SPACE) begin
            if (run_width != 0) begin
                brk_pos      = at;
                brk_seen     = 1'b1;
                width_to_brk = run_width;
                brk_width    = w;
                run_width    = sat16(reach);
            end else begin
                line_head = after;
                run_width = '0;
                forget_brk();
            end
        end else begin
            run_width = sat16(reach);
        end
        return made;
    endfunction

    task automatic report(input string what, input int got, input int want);
        if (errors < 100)
            $display("line_checker: %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        line_rec_t want;
        line_rec_t next_line;
        if (!rst_n) begin
            wrap_limit = GWW_MAX_WIDTH_RESET;
            line_head  = '0;
            run_width  = '0;
            forget_brk();
            lines_due.delete();
            pending = 0;
        end else begin
            if (max_width_wr)
                wrap_limit = max_width;
            if (line_valid && !line_stall) begin
                if (lines_due.size() == 0) begin
                    report("line item with none expected, line_start", line_start, 0);
                end else begin
                    want = lines_due.pop_front();
                    if (line_start != want.lstart)
                        report("line_start", line_start, want.lstart);
                    if (line_len != want.llen)
                        report("line_len", line_len, want.llen);
                    if (line_width != want.lwidth)
                        report("line_width", line_width, want.lwidth);
                    if (final_line != want.lfinal)
                        report("final_line", final_line, want.lfinal);
                end
            end
            if (char_valid && !char_stall) begin
                if (wrap_char(kind, char_width, char_pos, char_len, next_line))
                    lines_due.push_back(next_line);
            end
            pending = lines_due.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import gww_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 140;
    localparam int PHASES        = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        max_width_wr = 1'b0;
    logic [15:0] max_width    = '0;
    logic        char_valid   = 1'b0;
    logic        char_stall;
    logic [2:0]  kind         = '0;
    logic [7:0]  char_width   = '0;
    logic [15:0] char_pos     = '0;
    logic [2:0]  char_len     = '0;
    logic        line_valid;
    logic        line_stall   = 1'b0;
    logic [15:0] line_start;
    logic [15:0] line_len;
    logic [15:0] line_width;
    logic        final_line;

    int          pending;
    int          errors;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          chars_sent = 0;
    int          cycles     = 0;
    logic [15:0] text_pos   = '0;
    logic        hold_armed = 1'b0;
    logic        hold_on    = 1'b0;

    greedy_word_wrap dut (.*);

    line_checker u_lines (.*);

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        line_stall <= hold_on || ($urandom_range(0, 99) < stall_pct);

    // The receiver is held off for a long stretch so that the block backs up onto its input.
    initial begin
        wait (hold_armed);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    task automatic send_char(input logic [2:0] k, input logic [7:0] w, input logic [2:0] l);
        while ($urandom_range(0, 99) < idle_pct) begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        kind       <= k;
        char_width <= w;
        char_pos   <= text_pos;
        char_len   <= l;
        text_pos = text_pos + l;
        do @(posedge clk); while (char_stall);
        if (k == KIND_ORDINARY || k == KIND_SPACE || k == KIND_NEWLINE || k == KIND_EOT)
            chars_sent++;
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int          goal;
        int          words;
        int          wlen;
        int unsigned pick;
        logic [15:0] limit_now;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char(KIND_NEWLINE, 8'd0, 3'd1);
        send_char(KIND_SPACE, 8'd10, 3'd1);
        send_char(KIND_ORDINARY, 8'd255, 3'd4);
        send_char(KIND_ORDINARY, 8'd0, 3'd0);
        send_char(KIND_SPACE, 8'd5, 3'd1);
        send_char(KIND_ORDINARY, 8'd60, 3'd2);
        send_char(KIND_ORDINARY, 8'd1, 3'd3);
        send_char(KIND_CR, 8'd255, 3'd1);
        for (int k = KIND_EOT + 1; k < 8; k++)
            send_char(3'(k), 8'hAA, 3'd2);
        send_char(KIND_NEWLINE, 8'd7, 3'd1);
        send_char(KIND_ORDINARY, 8'd255, 3'd1);
        send_char(KIND_ORDINARY, 8'd255, 3'd1);
        send_char(KIND_SPACE, 8'd200, 3'd1);
        send_char(KIND_ORDINARY, 8'd20, 3'd2);
        send_char(KIND_EOT, 8'd0, 3'd0);
        send_char(KIND_EOT, 8'd0, 3'd0);
        text_pos = 16'hFFFE;
        send_char(KIND_ORDINARY, 8'd10, 3'd4);
        text_pos = 16'hFFFF;
        send_char(KIND_NEWLINE, 8'd0, 3'd4);
        text_pos = 16'h8000;
        send_char(KIND_ORDINARY, 8'hFF, 3'd1);
        text_pos = 16'h0001;
        send_char(KIND_EOT, 8'd0, 3'd0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       limit_now = GWW_MAX_WIDTH_RESET;
                1:       limit_now = 16'd0;
                2, 6:    limit_now = 16'hFFFF;
                3:       limit_now = 16'd40;
                4:       limit_now = 16'd100;
                5:       limit_now = 16'($urandom_range(1, 65534));
                default: limit_now = 16'd1000;
            endcase
            settle();
            max_width_wr <= 1'b1;
            max_width    <= limit_now;
            @(posedge clk);
            max_width_wr <= 1'b0;

            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 8;  stall_pct = 8;  end
            endcase
            if (phase == 4)
                hold_armed = 1'b1;
            goal = chars_sent + PHASE_ITEMS;

            // A narrow space after a one-pixel word, then a very wide run, drives the
            // width carried over a break into saturation.
            if (limit_now == 16'hFFFF) begin
                send_char(KIND_ORDINARY, 8'd1, 3'd1);
                send_char(KIND_SPACE, 8'd0, 3'd1);
                repeat (340) send_char(KIND_ORDINARY, 8'($urandom_range(200, 255)), 3'd1);
                send_char(KIND_NEWLINE, 8'd0, 3'd1);
            end

            while (chars_sent < goal) begin
                if ($urandom_range(0, 99) < 80) begin
                    if ($urandom_range(0, 3) == 0)
                        text_pos = 16'($urandom);
                    words = $urandom_range(1, 12);
                    repeat (words) begin
                        wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 8);
                        repeat (wlen) begin
                            pick = $urandom_range(0, 19);
                            send_char(KIND_ORDINARY,
                                      (pick == 0) ? 8'd0 :
                                      (pick == 1) ? 8'd255 :
                                      (pick < 4)  ? 8'($urandom) : 8'($urandom_range(4, 40)),
                                      3'($urandom_range((pick == 5) ? 0 : 1, 4)));
                        end
                        repeat ($urandom_range(1, 2))
                            send_char(KIND_SPACE,
                                      ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                  : 8'($urandom_range(0, 12)),
                                      3'd1);
                        pick = $urandom_range(0, 19);
                        if (pick == 0)
                            send_char(KIND_CR, 8'($urandom), 3'd1);
                        if (pick < 3)
                            send_char(KIND_NEWLINE, 8'($urandom), 3'($urandom_range(1, 2)));
                    end
                    if ($urandom_range(0, 9) < 7)
                        send_char(KIND_EOT, 8'($urandom), 3'd0);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        text_pos = 16'($urandom);
                        send_char(3'($urandom), 8'($urandom), 3'($urandom_range(0, 4)));
                    end
                end
            end
        end

        settle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
